### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // heap geometry in granules
    localparam int MAX_GRANULES  = 65536;
    localparam int INIT_GRANULES = 4096;
    localparam int MIN_GROW      = 4096;
    localparam int PAGE_GRAN     = 256;
    localparam int PAGE_SHIFT    = 8;
    localparam int GRAN_SHIFT    = 4;
    localparam logic [8:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] alloc_bytes;
        logic [19:0] free_offset;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] payload_offset;
        logic [19:0] free_bytes;
        logic [20:0] heap_bytes;
    } t_out_beat;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_DAT  = 6'b000100,
        S_WR   = 6'b001000,
        S_GROW = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef enum logic [3:0] {
        P_ALLOC  = 4'b0001,
        P_FWALK  = 4'b0010,
        P_FMERGE = 4'b0100,
        P_COUNT  = 4'b1000
    } t_phase;

endpackage

### rtl/core/ffha_store.sv
// ----------------------------------------------------------------------------
// ffha_store
// Block header store: payload size and free flag per granule, one write and
// one registered read a cycle. Entry 0 reads as the initial free block until
// it is first written.
// ----------------------------------------------------------------------------
module ffha_store #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wsize,
    input  logic          i_wfree,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rsize,
    output logic          o_rfree
);

    logic [AW-1:0] r_size_mem [2**AW];
    logic          r_free_mem [2**AW];
    logic [AW-1:0] r_rsize;
    logic          r_rfree;
    logic          r_e0_dflt;
    logic          r_rd_dflt;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_size_mem[i_waddr] <= i_wsize;
            r_free_mem[i_waddr] <= i_wfree;
        end
        r_rsize <= r_size_mem[i_raddr];
        r_rfree <= r_free_mem[i_raddr];
    end

    // entry 0 default until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_dflt <= 1'b1;
            r_rd_dflt <= 1'b0;
        end else begin
            if (i_we && i_waddr == '0) begin
                r_e0_dflt <= 1'b0;
            end
            r_rd_dflt <= r_e0_dflt && i_raddr == '0;
        end
    end

    assign o_rsize = r_rd_dflt ? AW'(ffha_pkg::INIT_GRANULES - 1) : r_rsize;
    assign o_rfree = r_rd_dflt ? 1'b1 : r_rfree;

endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// Sequence: accept, one header read per block visited in each walk, the header
// writes, a final pass over all blocks to count free space, then the result
// beat; an alloc that grows the heap walks again after growth.
// Throughput: one item at a time; input is taken only while the sequencer is idle.
// Reset: synchronous, active low; heap back to 4096 granules, cap to 256 pages.
// The header store is not swept: entry 0 reads as one free block until written.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator with header walk, split, growth and coalescing, run by a
// small sequencer around one header store and shared address arithmetic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module first_fit_heap_allocator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffha_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffha_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_wdata
);

    localparam int AW = $clog2(ffha_pkg::MAX_GRANULES);
    localparam int HW = AW + 1;
    localparam int CW = (AW + 2 > 25) ? AW + 2 : 25;

    ffha_pkg::t_state r_state, n_state;
    ffha_pkg::t_phase r_phase, n_phase;
    logic [HW-1:0] r_heap, n_heap;
    logic [8:0]    r_cap, n_cap;
    logic [HW-1:0] r_o, n_o;
    logic [AW-1:0] r_t, n_t;
    logic [CW-1:0] r_req, n_req;
    logic [AW-1:0] r_s, n_s;
    logic [AW-1:0] r_prev, n_prev;
    logic [AW-1:0] r_prev_size, n_prev_size;
    logic          r_prev_free, n_prev_free;
    logic          r_have_prev, n_have_prev;
    logic          r_first, n_first;
    logic [15:0]   r_total, n_total;
    logic [1:0]    r_status, n_status;
    logic [19:0]   r_payload, n_payload;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [AW-1:0] r_wsize, n_wsize;
    logic          r_wfree, n_wfree;
    logic          r_wmore, n_wmore;
    logic [AW-1:0] r_w2addr, n_w2addr;
    logic [AW-1:0] r_w2size, n_w2size;
    logic          r_w2free, n_w2free;

    logic [AW-1:0] rd_size;
    logic          rd_free;
    logic [CW-1:0] heap_c, o_c, rs_c, nxt_c, t_c, off_t, cap_c, chunk, sum_s, n_c;

    ffha_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_state == ffha_pkg::S_WR),
        .i_waddr (r_waddr),
        .i_wsize (r_wsize),
        .i_wfree (r_wfree),
        .i_raddr (r_o[AW-1:0]),
        .o_rsize (rd_size),
        .o_rfree (rd_free)
    );

    // shared address arithmetic and operand extension
    always_comb begin
        heap_c = CW'(r_heap);
        o_c    = CW'(r_o);
        rs_c   = CW'(rd_size);
        t_c    = CW'(r_t);
        nxt_c  = o_c + CW'(1) + rs_c;
        off_t  = CW'(i_in_data.free_offset >> ffha_pkg::GRAN_SHIFT) - CW'(1);
        cap_c  = CW'(r_cap) << ffha_pkg::PAGE_SHIFT;
        if (cap_c > CW'(ffha_pkg::MAX_GRANULES)) begin
            cap_c = CW'(ffha_pkg::MAX_GRANULES);
        end
        chunk = r_req + CW'(1);
        if (chunk < CW'(ffha_pkg::MIN_GROW)) begin
            chunk = CW'(ffha_pkg::MIN_GROW);
        end
        chunk = (chunk + CW'(ffha_pkg::PAGE_GRAN - 1)) & ~CW'(ffha_pkg::PAGE_GRAN - 1);
        if (chunk > cap_c - heap_c) begin
            chunk = cap_c - heap_c;
        end
        sum_s = r_first ? rs_c : CW'(r_s) + CW'(1) + rs_c;
        n_c   = t_c + CW'(1) + sum_s;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_heap      = r_heap;
        n_cap       = i_cfg_we ? i_cfg_wdata : r_cap;
        n_o         = r_o;
        n_t         = r_t;
        n_req       = r_req;
        n_s         = r_s;
        n_prev      = r_prev;
        n_prev_size = r_prev_size;
        n_prev_free = r_prev_free;
        n_have_prev = r_have_prev;
        n_first     = r_first;
        n_total     = r_total;
        n_status    = r_status;
        n_payload   = r_payload;
        n_waddr     = r_waddr;
        n_wsize     = r_wsize;
        n_wfree     = r_wfree;
        n_wmore     = r_wmore;
        n_w2addr    = r_w2addr;
        n_w2size    = r_w2size;
        n_w2free    = r_w2free;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_status  = ffha_pkg::ST_DONE;
                    n_payload = '0;
                    n_o       = '0;
                    n_total   = '0;
                    n_state   = ffha_pkg::S_RD;
                    n_phase   = ffha_pkg::P_COUNT;
                    unique case (i_in_data.cmd)
                        ffha_pkg::CMD_ALLOC: begin
                            n_req   = (CW'(i_in_data.alloc_bytes) + CW'(15))
                                      >> ffha_pkg::GRAN_SHIFT;
                            n_phase = ffha_pkg::P_ALLOC;
                        end
                        ffha_pkg::CMD_FREE: begin
                            n_have_prev = 1'b0;
                            n_first     = 1'b1;
                            n_t         = off_t[AW-1:0];
                            if (i_in_data.free_offset[3:0] != 4'd0 ||
                                i_in_data.free_offset < 20'd16 || off_t >= heap_c) begin
                                n_status = ffha_pkg::ST_BADFREE;
                            end else if (off_t == '0) begin
                                n_phase = ffha_pkg::P_FMERGE;
                            end else begin
                                n_phase = ffha_pkg::P_FWALK;
                            end
                        end
                        ffha_pkg::CMD_RESET: begin
                            n_waddr = '0;
                            n_wsize = AW'(r_heap - HW'(1));
                            n_wfree = 1'b1;
                            n_wmore = 1'b0;
                            n_state = ffha_pkg::S_WR;
                        end
                        default: begin
                            n_phase = ffha_pkg::P_COUNT;
                        end
                    endcase
                end
            end
            ffha_pkg::S_RD: begin
                n_state = ffha_pkg::S_DAT;
            end
            ffha_pkg::S_DAT: begin
                unique case (r_phase)
                    ffha_pkg::P_COUNT: begin
                        if (rd_free) begin
                            n_total = r_total + 16'(rd_size);
                        end
                        if (nxt_c < heap_c) begin
                            n_o     = HW'(nxt_c);
                            n_state = ffha_pkg::S_RD;
                        end else begin
                            n_state = ffha_pkg::S_DONE;
                        end
                    end
                    ffha_pkg::P_ALLOC: begin
                        if (rd_free && rs_c >= r_req) begin
                            n_phase   = ffha_pkg::P_COUNT;
                            n_state   = ffha_pkg::S_WR;
                            n_payload = {16'(o_c + CW'(1)), 4'd0};
                            if (rs_c >= r_req + CW'(2)) begin
                                n_waddr  = AW'(o_c + CW'(1) + r_req);
                                n_wsize  = AW'(rs_c - r_req - CW'(1));
                                n_wfree  = 1'b1;
                                n_wmore  = 1'b1;
                                n_w2addr = r_o[AW-1:0];
                                n_w2size = AW'(r_req);
                                n_w2free = 1'b0;
                            end else begin
                                n_waddr = r_o[AW-1:0];
                                n_wsize = rd_size;
                                n_wfree = 1'b0;
                                n_wmore = 1'b0;
                            end
                        end else if (nxt_c < heap_c) begin
                            n_o     = HW'(nxt_c);
                            n_state = ffha_pkg::S_RD;
                        end else begin
                            n_state = ffha_pkg::S_GROW;
                        end
                    end
                    ffha_pkg::P_FWALK: begin
                        n_prev      = r_o[AW-1:0];
                        n_prev_size = rd_size;
                        n_prev_free = rd_free;
                        n_have_prev = 1'b1;
                        if (nxt_c < heap_c && nxt_c < t_c) begin
                            n_o     = HW'(nxt_c);
                            n_state = ffha_pkg::S_RD;
                        end else if (nxt_c != t_c) begin
                            n_status = ffha_pkg::ST_BADFREE;
                            n_phase  = ffha_pkg::P_COUNT;
                            n_o      = '0;
                            n_total  = '0;
                            n_state  = ffha_pkg::S_RD;
                        end else begin
                            n_phase = ffha_pkg::P_FMERGE;
                            n_first = 1'b1;
                            n_o     = HW'(t_c);
                            n_state = ffha_pkg::S_RD;
                        end
                    end
                    default: begin
                        // forward coalescing from the freed block, then merge into a free predecessor
                        if (r_first || rd_free) begin
                            n_s     = AW'(sum_s);
                            n_first = 1'b0;
                        end
                        if ((r_first || rd_free) && n_c < heap_c) begin
                            n_o     = HW'(n_c);
                            n_state = ffha_pkg::S_RD;
                        end else begin
                            n_waddr  = r_t;
                            n_wsize  = n_s;
                            n_wfree  = 1'b1;
                            n_wmore  = r_have_prev && r_prev_free;
                            n_w2addr = r_prev;
                            n_w2size = r_prev_size + AW'(1) + n_s;
                            n_w2free = 1'b1;
                            n_phase  = ffha_pkg::P_COUNT;
                            n_state  = ffha_pkg::S_WR;
                        end
                    end
                endcase
            end
            ffha_pkg::S_WR: begin
                if (r_wmore) begin
                    n_waddr = r_w2addr;
                    n_wsize = r_w2size;
                    n_wfree = r_w2free;
                    n_wmore = 1'b0;
                end else begin
                    n_o     = '0;
                    n_total = '0;
                    n_state = ffha_pkg::S_RD;
                end
            end
            ffha_pkg::S_GROW: begin
                if (heap_c >= cap_c) begin
                    n_status = ffha_pkg::ST_OOM;
                    n_phase  = ffha_pkg::P_COUNT;
                    n_o      = '0;
                    n_total  = '0;
                    n_state  = ffha_pkg::S_RD;
                end else begin
                    // new free block at the heap end, then walk again
                    n_waddr = r_heap[AW-1:0];
                    n_wsize = AW'(chunk - CW'(1));
                    n_wfree = 1'b1;
                    n_wmore = 1'b0;
                    n_heap  = HW'(heap_c + chunk);
                    n_state = ffha_pkg::S_WR;
                end
            end
            default: begin
                if (i_out_ready) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
            r_phase <= ffha_pkg::P_COUNT;
            r_heap  <= HW'(ffha_pkg::INIT_GRANULES);
            r_cap   <= ffha_pkg::CAP_RESET;
            r_wmore <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_heap  <= n_heap;
            r_cap   <= n_cap;
            r_wmore <= n_wmore;
            r_first <= n_first;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_o         <= n_o;
        r_t         <= n_t;
        r_req       <= n_req;
        r_s         <= n_s;
        r_prev      <= n_prev;
        r_prev_size <= n_prev_size;
        r_prev_free <= n_prev_free;
        r_have_prev <= n_have_prev;
        r_total     <= n_total;
        r_status    <= n_status;
        r_payload   <= n_payload;
        r_waddr     <= n_waddr;
        r_wsize     <= n_wsize;
        r_wfree     <= n_wfree;
        r_w2addr    <= n_w2addr;
        r_w2size    <= n_w2size;
        r_w2free    <= n_w2free;
    end

    // handshake and result beat
    assign o_in_ready  = r_state == ffha_pkg::S_IDLE;
    assign o_out_valid = r_state == ffha_pkg::S_DONE;
    assign o_out_data.status         = r_status;
    assign o_out_data.payload_offset = r_payload;
    assign o_out_data.free_bytes     = {r_total, 4'd0};
    assign o_out_data.heap_bytes     = {heap_c[16:0], 4'd0};

    `ASSERT_IMPL(a_ready_excl, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_heap_mono, 1'b1, r_heap >= $past(r_heap))
    `ASSERT_IMPL(a_heap_max, 1'b1, r_heap <= HW'(ffha_pkg::MAX_GRANULES))

endmodule

### bench/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Watches both beat channels of the first-fit heap allocator. It keeps a
// shadow heap of block headers and predicts every result beat, then compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
module ffha_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ffha_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ffha_pkg::t_out_beat i_out_data,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count,
    output int                  o_grow_count,
    output int                  o_oom_count,
    output int                  o_badfree_count
);

    localparam int HEAP_LIMIT = 65536;

    // shadow heap
    int unsigned         blk_size [HEAP_LIMIT];
    bit                  blk_free [HEAP_LIMIT];
    int unsigned         heap_gran;
    logic [8:0]          cap_pages;
    ffha_pkg::t_out_beat expected_beats[$];

    function automatic int unsigned size_at(int unsigned o);
        return (o < HEAP_LIMIT) ? blk_size[o] : 0;
    endfunction

    function automatic bit free_at(int unsigned o);
        return (o < HEAP_LIMIT) ? blk_free[o] : 1'b0;
    endfunction

    function automatic void set_block(int unsigned o, int unsigned s, bit f);
        if (o < HEAP_LIMIT) begin
            blk_size[o] = s;
            blk_free[o] = f;
        end
    endfunction

    function automatic logic [19:0] sum_free_bytes();
        int unsigned o;
        int unsigned total;
        o = 0;
        total = 0;
        while (o < heap_gran) begin
            if (free_at(o)) total += size_at(o);
            o += 1 + size_at(o);
        end
        return 20'((total * 16) & 32'hFFFFF);
    endfunction

    // first-fit search, growing the heap when nothing fits
    function automatic logic [1:0] alloc_block(int unsigned nbytes, output logic [19:0] payload);
        int unsigned req;
        int unsigned o;
        int unsigned s;
        int unsigned cap;
        int unsigned chunk;
        req = (nbytes + 15) / 16;
        payload = '0;
        forever begin
            o = 0;
            while (o < heap_gran) begin
                s = size_at(o);
                if (free_at(o) && s >= req) begin
                    if (s >= req + 2) begin
                        set_block(o + 1 + req, s - req - 1, 1'b1);
                        s = req;
                    end
                    set_block(o, s, 1'b0);
                    payload = 20'(((o + 1) * 16) & 32'hFFFFF);
                    return ffha_pkg::ST_DONE;
                end
                o += 1 + s;
            end
            cap = cap_pages * ffha_pkg::PAGE_GRAN;
            if (cap > HEAP_LIMIT) cap = HEAP_LIMIT;
            if (heap_gran >= cap) return ffha_pkg::ST_OOM;
            chunk = req + 1;
            if (chunk < ffha_pkg::MIN_GROW) chunk = ffha_pkg::MIN_GROW;
            if (chunk % ffha_pkg::PAGE_GRAN != 0)
                chunk += ffha_pkg::PAGE_GRAN - chunk % ffha_pkg::PAGE_GRAN;
            if (chunk > cap - heap_gran) chunk = cap - heap_gran;
            set_block(heap_gran, chunk - 1, 1'b1);
            heap_gran += chunk;
            o_grow_count++;
        end
    endfunction

    // free with forward coalescing, then merge into a free predecessor
    function automatic logic [1:0] free_block(int unsigned off);
        int unsigned t;
        int unsigned o;
        int unsigned prev;
        int unsigned s;
        int unsigned n;
        bit          has_prev;
        if (off % 16 != 0 || off < 16) return ffha_pkg::ST_BADFREE;
        t = off / 16 - 1;
        if (t >= heap_gran) return ffha_pkg::ST_BADFREE;
        o = 0;
        prev = 0;
        has_prev = 1'b0;
        while (o < heap_gran && o < t) begin
            prev = o;
            has_prev = 1'b1;
            o += 1 + size_at(o);
        end
        if (o != t) return ffha_pkg::ST_BADFREE;
        s = size_at(t);
        n = t + 1 + s;
        while (n < heap_gran && free_at(n)) begin
            s += 1 + size_at(n);
            n = t + 1 + s;
        end
        set_block(t, s, 1'b1);
        if (has_prev && free_at(prev)) set_block(prev, size_at(prev) + 1 + s, 1'b1);
        return ffha_pkg::ST_DONE;
    endfunction

    function automatic ffha_pkg::t_out_beat predict_result(ffha_pkg::t_in_beat b);
        ffha_pkg::t_out_beat r;
        logic [19:0] pay;
        r = '0;
        pay = '0;
        case (b.cmd)
            ffha_pkg::CMD_ALLOC: r.status = alloc_block(b.alloc_bytes, pay);
            ffha_pkg::CMD_FREE:  r.status = free_block(b.free_offset);
            ffha_pkg::CMD_RESET: set_block(0, heap_gran - 1, 1'b1);
            default:             r.status = ffha_pkg::ST_DONE;
        endcase
        r.payload_offset = pay;
        r.free_bytes = sum_free_bytes();
        r.heap_bytes = 21'((heap_gran * 16) & 32'h1FFFFF);
        if (r.status == ffha_pkg::ST_OOM) o_oom_count++;
        if (r.status == ffha_pkg::ST_BADFREE) o_badfree_count++;
        return r;
    endfunction

    assign o_pending = expected_beats.size();

    // predict on each input beat, compare on each output beat
    always @(posedge i_clk) begin
        ffha_pkg::t_out_beat want;
        if (!i_rst_n) begin
            foreach (blk_size[k]) begin
                blk_size[k] = 0;
                blk_free[k] = 1'b0;
            end
            blk_size[0] = ffha_pkg::INIT_GRANULES - 1;
            blk_free[0] = 1'b1;
            heap_gran = ffha_pkg::INIT_GRANULES;
            cap_pages = ffha_pkg::CAP_RESET;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) cap_pages = i_cfg_wdata;
            if (i_in_valid && i_in_ready) expected_beats.push_back(predict_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                        o_fail_count++;
                    end
                    if (i_out_data.payload_offset !== want.payload_offset) begin
                        $error("payload_offset: expected %0d, got %0d",
                            want.payload_offset, i_out_data.payload_offset);
                        o_fail_count++;
                    end
                    if (i_out_data.free_bytes !== want.free_bytes) begin
                        $error("free_bytes: expected %0d, got %0d",
                            want.free_bytes, i_out_data.free_bytes);
                        o_fail_count++;
                    end
                    if (i_out_data.heap_bytes !== want.heap_bytes) begin
                        $error("heap_bytes: expected %0d, got %0d",
                            want.heap_bytes, i_out_data.heap_bytes);
                        o_fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_grow_count = 0;
        o_oom_count = 0;
        o_badfree_count = 0;
    end

endmodule

### bench/tb_first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Drives alloc, free, heap reset and no-op beats with random gaps and back-pressure,
// walks the growth cap through several settings and lets the checker judge.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    ffha_pkg::t_in_beat  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    ffha_pkg::t_out_beat o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [8:0]          i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int result_count;
    int grow_count;
    int oom_count;
    int badfree_count;
    bit calm_mode = 1'b0;
    int sent_count = 0;

    // offsets handed out and not yet returned
    logic [19:0] live_offsets[$];

    always #2 i_clk = ~i_clk;

    first_fit_heap_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    ffha_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_grow_count   (grow_count),
        .o_oom_count    (oom_count),
        .o_badfree_count(badfree_count)
    );

    // learn granted offsets from the result channel
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready && o_out_data.status == ffha_pkg::ST_DONE
            && o_out_data.payload_offset != 0)
            live_offsets.push_back(o_out_data.payload_offset);
        if (o_out_valid && i_out_ready && o_out_data.heap_bytes != 0 && live_offsets.size() > 400)
            void'(live_offsets.pop_front());
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 30);
    end

    // valid stays up after a beat unless an idle cycle follows
    task automatic send_beat(input logic [1:0] c, input logic [23:0] nb, input logic [19:0] off);
        if (!calm_mode) begin
            while ($urandom_range(99) < 30) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{cmd: c, alloc_bytes: nb, free_offset: off};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [8:0] pages);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= pages;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_free_of_live();
        int k;
        logic [19:0] off;
        if (live_offsets.size() == 0) begin
            send_beat(ffha_pkg::CMD_FREE, 24'($urandom), 20'd16);
        end else begin
            k = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[k];
            live_offsets.delete(k);
            send_beat(ffha_pkg::CMD_FREE, 24'($urandom), off);
        end
    endtask

    // one random beat, mostly alloc/free of live blocks with small sizes
    task automatic send_random_beat();
        int pick;
        logic [23:0] nb;
        pick = $urandom_range(99);
        if (pick < 45) begin
            if ($urandom_range(19) == 0) nb = 24'($urandom);
            else if ($urandom_range(9) == 0) nb = 24'($urandom_range(70000));
            else nb = 24'($urandom_range(600));
            send_beat(ffha_pkg::CMD_ALLOC, nb, 20'($urandom));
        end else if (pick < 85) begin
            send_free_of_live();
        end else if (pick < 93) begin
            send_beat(ffha_pkg::CMD_FREE, 24'($urandom), 20'($urandom));
        end else if (pick < 96) begin
            live_offsets.delete();
            send_beat(ffha_pkg::CMD_RESET, 24'($urandom), 20'($urandom));
        end else begin
            send_beat(ffha_pkg::CMD_NOP, 24'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        logic [8:0] caps [4];
        caps = '{9'd16, 9'd255, 9'd40, 9'd256};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command and the special cases
        send_beat(ffha_pkg::CMD_ALLOC, 24'd0, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd1, 20'hFFFFF);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd16, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd17, '0);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd32);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd32);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd16);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd0);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd17);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'hFFFF0);
        send_beat(ffha_pkg::CMD_FREE, '0, 20'd48);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd65520, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd100000, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'hFFFFFF, '0);
        send_beat(ffha_pkg::CMD_NOP, 24'hFFFFFF, 20'hFFFFF);
        send_beat(ffha_pkg::CMD_RESET, '0, '0);
        live_offsets.delete();
        write_cap(9'd16);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd70000, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd65000, '0);
        write_cap(9'd511);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd500000, '0);
        send_beat(ffha_pkg::CMD_ALLOC, 24'd2000, '0);
        send_beat(ffha_pkg::CMD_RESET, '0, '0);
        live_offsets.delete();
        write_cap(9'd0);

        // random phases across cap settings, one stretch without idling
        for (int ph = 0; ph < 4; ph++) begin
            write_cap(caps[ph]);
            calm_mode = (ph == 1);
            repeat (220) send_random_beat();
            if (ph == 2) drain_results();
        end
        calm_mode = 1'b0;

        drain_results();
        $display("Covered %0d beats: %0d grows, %0d out-of-memory, %0d rejected frees.",
            sent_count, grow_count, oom_count, badfree_count);
        $display("Growth cap walked through 16, 255, 40, 256, 0 and 511 pages.");
        if (fail_count == 0 && result_count == sent_count) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
